>>> hw/rtl/mrtd_pkg.sv
// mrtd_pkg: shared types, constants and helpers for the multi-rate task dispatcher
// used by mrtd_cfg, mrtd_core and multi_rate_task_dispatcher; no dependencies
package mrtd_pkg;

	localparam int MAX_TASKS = 16;
	localparam int CNT_W     = 4;
	localparam int SLOT_W    = 4;
	localparam int IDX_W     = 3;
	localparam int NUM_REGS  = 5;

	// divider moduli of the cascade
	localparam int DIV_BASE = 9;
	localparam int DIV_2K   = 10;
	localparam int DIV_200  = 4;
	localparam int DIV_50   = 5;

	localparam int BASE_W = 4;
	localparam int D2K_W  = 4;
	localparam int D200_W = 3;
	localparam int D50_W  = 3;

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 16;

	typedef enum logic [IDX_W-1:0] {
		REG_FAST_COUNT = 3'd0,
		REG_2K_COUNT   = 3'd1,
		REG_200_COUNT  = 3'd2,
		REG_50_COUNT   = 3'd3,
		REG_10_COUNT   = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		GRP_2K  = 2'd0,
		GRP_200 = 2'd1,
		GRP_50  = 2'd2,
		GRP_10  = 2'd3
	} group_t;

	typedef struct packed {
		logic [CNT_W-1:0] fast_count;
		logic [CNT_W-1:0] cnt_2k;
		logic [CNT_W-1:0] cnt_200;
		logic [CNT_W-1:0] cnt_50;
		logic [CNT_W-1:0] cnt_10;
	} cfg_t;

	typedef struct packed {
		logic              fast_run;
		logic              early_valid;
		logic [SLOT_W-1:0] early_index;
		logic              chain_valid;
		group_t            chain_group;
		logic [SLOT_W-1:0] chain_index;
		logic [2:0]        wrap_level;
	} result_t;

	// group sizes above the slot range saturate at the last slot
	function automatic logic [SLOT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
		logic [SLOT_W-1:0] r;
		if (int'(c) > MAX_TASKS - 1)
			r = SLOT_W'(MAX_TASKS - 1);
		else
			r = SLOT_W'(c);
		return r;
	endfunction

endpackage

>>> hw/rtl/mrtd_cfg.sv
// mrtd_cfg: configuration register file of the dispatcher (group task counts)
// depends on mrtd_pkg
module mrtd_cfg (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [mrtd_pkg::IDX_W-1:0] cfg_index,
	input  logic [mrtd_pkg::CNT_W-1:0] cfg_data,
	output mrtd_pkg::cfg_t           cfg
);
	import mrtd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FAST_COUNT: cfg_q.fast_count <= cfg_data;
				REG_2K_COUNT:   cfg_q.cnt_2k     <= cfg_data;
				REG_200_COUNT:  cfg_q.cnt_200    <= cfg_data;
				REG_50_COUNT:   cfg_q.cnt_50     <= cfg_data;
				REG_10_COUNT:   cfg_q.cnt_10     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hw/rtl/mrtd_core.sv
// mrtd_core: dispatch state (dividers, per-group slot indexes) and the
// single-pass tick update; depends on mrtd_pkg
module mrtd_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             tick,
	input  mrtd_pkg::cfg_t   cfg,
	output mrtd_pkg::result_t res
);
	import mrtd_pkg::*;

	logic [BASE_W-1:0] base_div_q;
	logic [D2K_W-1:0]  div_2k_q;
	logic [D200_W-1:0] div_200_q;
	logic [D50_W-1:0]  div_50_q;
	logic [SLOT_W-1:0] slot_q [4];

	logic [SLOT_W-1:0] cnt [4];
	logic [SLOT_W-1:0] slot_a [4];
	logic [SLOT_W-1:0] slot_b [4];
	logic [SLOT_W-1:0] slot_n [4];
	logic              early_v;
	logic              chain_v;
	logic [1:0]        chain_g;
	logic [BASE_W-1:0] base_inc, base_n;
	logic [D2K_W-1:0]  d2k_inc, d2k_n;
	logic [D200_W-1:0] d200_inc, d200_n;
	logic [D50_W-1:0]  d50_inc, d50_n;
	logic              w1, w2, w3, w4;

	always_comb begin
		cnt[0] = clamp_count(cfg.cnt_2k);
		cnt[1] = clamp_count(cfg.cnt_200);
		cnt[2] = clamp_count(cfg.cnt_50);
		cnt[3] = clamp_count(cfg.cnt_10);

		// slow group task goes out ahead of the chain
		slot_a  = slot_q;
		early_v = slot_q[3] < cnt[3];
		if (early_v)
			slot_a[3] = slot_q[3] + 1'b1;

		// priority chain sees the already advanced slow index
		slot_b  = slot_a;
		chain_v = 1'b0;
		chain_g = '0;
		priority if (slot_a[0] < cnt[0]) begin
			chain_v = 1'b1;
			chain_g = 2'd0;
		end else if (slot_a[1] < cnt[1]) begin
			chain_v = 1'b1;
			chain_g = 2'd1;
		end else if (slot_a[2] < cnt[2]) begin
			chain_v = 1'b1;
			chain_g = 2'd2;
		end else if (slot_a[3] < cnt[3]) begin
			chain_v = 1'b1;
			chain_g = 2'd3;
		end else begin
			chain_v = 1'b0;
		end
		if (chain_v)
			slot_b[chain_g] = slot_a[chain_g] + 1'b1;

		// divider cascade
		base_inc = base_div_q + 1'b1;
		d2k_inc  = div_2k_q + 1'b1;
		d200_inc = div_200_q + 1'b1;
		d50_inc  = div_50_q + 1'b1;
		w1 = int'(base_inc) >= DIV_BASE;
		w2 = w1 && (int'(d2k_inc) >= DIV_2K);
		w3 = w2 && (int'(d200_inc) >= DIV_200);
		w4 = w3 && (int'(d50_inc) >= DIV_50);

		base_n = w1 ? '0 : base_inc;
		d2k_n  = w2 ? '0 : (w1 ? d2k_inc : div_2k_q);
		d200_n = w3 ? '0 : (w2 ? d200_inc : div_200_q);
		d50_n  = w4 ? '0 : (w3 ? d50_inc : div_50_q);

		slot_n    = slot_b;
		if (w1) slot_n[0] = '0;
		if (w2) slot_n[1] = '0;
		if (w3) slot_n[2] = '0;
		if (w4) slot_n[3] = '0;

		res = '0;
		if (tick) begin
			res.fast_run    = cfg.fast_count != '0;
			res.early_valid = early_v;
			res.early_index = early_v ? slot_q[3] : '0;
			res.chain_valid = chain_v;
			res.chain_group = group_t'(chain_g);
			res.chain_index = chain_v ? slot_a[chain_g] : '0;
			res.wrap_level  = w4 ? 3'd4 : w3 ? 3'd3 : w2 ? 3'd2 : w1 ? 3'd1 : 3'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_div_q <= '0;
			div_2k_q   <= '0;
			div_200_q  <= '0;
			div_50_q   <= '0;
			for (int i = 0; i < 4; i++)
				slot_q[i] <= '0;
		end else if (step && tick) begin
			base_div_q <= base_n;
			div_2k_q   <= d2k_n;
			div_200_q  <= d200_n;
			div_50_q   <= d50_n;
			slot_q     <= slot_n;
		end
	end

endmodule

>>> hw/rtl/multi_rate_task_dispatcher.sv
// multi_rate_task_dispatcher: one base tick in, one dispatch record out
// registered result valid in the next cycle; one tick per cycle unless output stalls
// the tick update is one pass of compares and increments ahead of the output register
// input is taken while a result waits if the result is taken in the same cycle
// reset (arst_n low) clears counts, dividers, slot indexes and the output register
module multi_rate_task_dispatcher (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [mrtd_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [0] tick, rest zero
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [0] fast_run, [1] early_slow_valid, [5:2] early_slow_index, [6] chain_valid,
	// [8:7] chain_group, [12:9] chain_index, [15:13] wrap_level
	output logic [mrtd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input  logic                              cfg_we,
	input  logic [mrtd_pkg::IDX_W-1:0]        cfg_index,
	input  logic [mrtd_pkg::CNT_W-1:0]        cfg_data
);
	import mrtd_pkg::*;

	cfg_t    cfg;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    accept;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	mrtd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mrtd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (accept),
		.tick   (s_axis_tdata[0]),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (accept) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {res_q.wrap_level, res_q.chain_index, res_q.chain_group,
		res_q.chain_valid, res_q.early_index, res_q.early_valid, res_q.fast_run};

`ifndef SYNTHESIS
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("accepted tick produced no result");

	a_wrap_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[15:13] <= 3'd4)
		else $error("wrap level out of range");

	a_chain_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[6] |-> m_axis_tdata[12:7] == 6'd0)
		else $error("chain fields set without a chain dispatch");

	a_slow_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1] && m_axis_tdata[6] && m_axis_tdata[8:7] == 2'd3
		|-> m_axis_tdata[12:9] == m_axis_tdata[5:2] + 4'd1)
		else $error("chained slow task does not follow the early slow task");
`endif

endmodule

>>> bench/multi_rate_task_dispatcher_tb.sv
// multi_rate_task_dispatcher_tb: stream testbench for the multi-rate task dispatcher
// a scoreboard class tracks the dividers and slot indexes and checks every dispatch record
// depends on mrtd_pkg and multi_rate_task_dispatcher
`timescale 1ns / 100ps

module multi_rate_task_dispatcher_tb;
	import mrtd_pkg::*;

	class dispatch_scoreboard;
		logic [CNT_W-1:0]  counts [NUM_REGS];
		logic [BASE_W-1:0] base_div;
		logic [D2K_W-1:0]  div_2k;
		logic [D200_W-1:0] div_200;
		logic [D50_W-1:0]  div_50;
		logic [SLOT_W-1:0] next_slot [4];
		result_t           pending [$];
		int                errors;

		function new();
			foreach (counts[i])
				counts[i] = '0;
			foreach (next_slot[i])
				next_slot[i] = '0;
			base_div    = '0;
			div_2k      = '0;
			div_200     = '0;
			div_50      = '0;
			errors      = 0;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [CNT_W-1:0] value);
			case (idx)
				REG_FAST_COUNT: counts[0] = value;
				REG_2K_COUNT:   counts[1] = value;
				REG_200_COUNT:  counts[2] = value;
				REG_50_COUNT:   counts[3] = value;
				REG_10_COUNT:   counts[4] = value;
				default: ;
			endcase
		endfunction

		// predict the record for one accepted tick transaction
		function void note_tick(logic tick);
			result_t           rec;
			logic [SLOT_W-1:0] lim [4];
			int                g;
			rec = '0;
			if (tick) begin
				for (g = 0; g < 4; g++)
					lim[g] = (int'(counts[g+1]) > MAX_TASKS - 1) ?
						SLOT_W'(MAX_TASKS - 1) : SLOT_W'(counts[g+1]);

				// a pending 10 Hz task goes ahead of the chain
				if (next_slot[GRP_10] < lim[GRP_10]) begin
					rec.early_valid = 1'b1;
					rec.early_index = next_slot[GRP_10];
					next_slot[GRP_10] = next_slot[GRP_10] + 1'b1;
				end
				for (g = 0; g < 4 && !rec.chain_valid; g++) begin
					if (next_slot[g] < lim[g]) begin
						rec.chain_valid = 1'b1;
						rec.chain_group = group_t'(g);
						rec.chain_index = next_slot[g];
						next_slot[g] = next_slot[g] + 1'b1;
					end
				end

				base_div = base_div + 1'b1;
				if (base_div >= DIV_BASE) begin
					base_div = '0;
					rec.wrap_level = 3'd1;
					next_slot[GRP_2K] = '0;
					div_2k = div_2k + 1'b1;
					if (div_2k >= DIV_2K) begin
						div_2k = '0;
						rec.wrap_level = 3'd2;
						next_slot[GRP_200] = '0;
						div_200 = div_200 + 1'b1;
						if (div_200 >= DIV_200) begin
							div_200 = '0;
							rec.wrap_level = 3'd3;
							next_slot[GRP_50] = '0;
							div_50 = div_50 + 1'b1;
							if (div_50 >= DIV_50) begin
								div_50 = '0;
								rec.wrap_level = 3'd4;
								next_slot[GRP_10] = '0;
							end
						end
					end
				end
				rec.fast_run = (counts[0] != '0);
			end
			pending.push_back(rec);
		endfunction

		function void compare(string field, logic [3:0] want, logic [3:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				errors++;
			end
		endfunction

		function void check_record(logic [OUT_DATA_W-1:0] d);
			result_t want;
			if (pending.size() == 0) begin
				$error("record %h with no tick outstanding", d);
				errors++;
				return;
			end
			want = pending.pop_front();
			compare("fast_run", 4'(want.fast_run), 4'(d[0]));
			compare("early_slow_valid", 4'(want.early_valid), 4'(d[1]));
			compare("early_slow_index", want.early_index, d[5:2]);
			compare("chain_valid", 4'(want.chain_valid), 4'(d[6]));
			compare("chain_group", 4'(want.chain_group), 4'(d[8:7]));
			compare("chain_index", want.chain_index, d[12:9]);
			compare("wrap_level", 4'(want.wrap_level), 4'(d[15:13]));
		endfunction
	endclass

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int LONG_HOLD      = 50;
	localparam int RANDOM_ITEMS   = 450;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_we;
	logic [IDX_W-1:0]      cfg_index;
	logic [CNT_W-1:0]      cfg_data;

	dispatch_scoreboard sb;
	logic               idle_on;
	logic               hold_outputs;
	int                 quiet_cycles;

	multi_rate_task_dispatcher i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// transaction monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_record(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready)
				sb.note_tick(s_axis_tdata[0]);
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// result side: random stalls, plus one long hold on request
	initial begin
		m_axis_tready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_outputs) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_outputs = 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic send_tick(input logic tick);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_DATA_W'(tick);
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	task automatic sender_gap();
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// stop offering and let every outstanding record drain
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending.size() != 0);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CNT_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		sb.write_reg(idx, value);
	endtask

	task automatic set_counts(input logic [CNT_W-1:0] fast, input logic [CNT_W-1:0] c2k,
			input logic [CNT_W-1:0] c200, input logic [CNT_W-1:0] c50,
			input logic [CNT_W-1:0] c10);
		write_reg(REG_FAST_COUNT, fast);
		write_reg(REG_2K_COUNT, c2k);
		write_reg(REG_200_COUNT, c200);
		write_reg(REG_50_COUNT, c50);
		write_reg(REG_10_COUNT, c10);
		cfg_we <= 1'b0;
	endtask

	task automatic write_bogus_reg();
		write_reg(IDX_W'($urandom_range(NUM_REGS, (1 << IDX_W) - 1)),
			CNT_W'($urandom_range(0, 15)));
		cfg_we <= 1'b0;
	endtask

	task automatic set_random_counts();
		set_counts(CNT_W'($urandom_range(0, 15)), CNT_W'($urandom_range(0, 15)),
			CNT_W'($urandom_range(0, 15)), CNT_W'($urandom_range(0, 15)),
			CNT_W'($urandom_range(0, 15)));
	endtask

	initial begin
		int n;
		int p;
		int len;
		int random_items;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		idle_on       = 1'b0;
		hold_outputs  = 1'b0;
		quiet_cycles  = 0;
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// counts still at zero: nothing dispatched, dividers run, non-tick leaves state alone
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
		drain();

		// one task per faster group and extra 10 Hz tasks, so the chain walks every group
		set_counts(4'd15, 4'd1, 4'd1, 4'd1, 4'd6);
		write_bogus_reg();
		repeat (5) send_tick(1'b1);
		send_tick(1'b0);
		repeat (6) send_tick(1'b1);

		// random phases, each with its own group counts
		random_items = 0;
		p = 0;
		while (random_items < RANDOM_ITEMS) begin
			drain();
			case (p)
				0: set_counts(4'd15, 4'd15, 4'd15, 4'd15, 4'd15);
				1: set_counts(4'd0, 4'd0, 4'd0, 4'd0, 4'd0);
				default: set_random_counts();
			endcase
			if ($urandom_range(0, 2) == 0)
				write_bogus_reg();
			idle_on = (p % 3 != 2) && (p != 3);
			len = $urandom_range(60, 120);
			for (n = 0; n < len; n++) begin
				// output held off while ticks keep coming, so the input backs up
				if (p == 3 && n == 5)
					hold_outputs = 1'b1;
				send_tick($urandom_range(0, 15) != 0);
				sender_gap();
			end
			random_items += len;
			p++;
		end

		// closing stretch with no idling on either side
		drain();
		set_random_counts();
		idle_on = 1'b0;
		repeat (40) send_tick($urandom_range(0, 15) != 0);
		drain();
		repeat (4) @(posedge clk);

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
